### hdl/pbag_pkg.sv
// Shared types, constants and the glyph lookup for the pixel block to glyph converter.
`timescale 1ns / 1ps
package pbag_pkg;

  localparam int RAMP_LEVELS = 10;
  localparam int PIX_W       = 8;
  localparam int IDX_W       = 4;
  localparam int GLYPH_W     = 7;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MIN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_SPAN = 8'd1;

  localparam logic [PIX_W-1:0] GRAY_MIN_RST  = 8'd0;
  localparam logic [PIX_W-1:0] GRAY_SPAN_RST = 8'd255;
  localparam logic [PIX_W-1:0] MID_GRAY      = 8'd128;

  // contrast gain 105365 / 65536, mid gray 128 in Q16
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 11;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam logic signed [MUL_A_W-1:0] GAIN_Q16  = 18'sd105365;
  localparam logic signed [MUL_A_W-1:0] RECIP3    = 18'sd683;   // 2048/3, shift 11
  localparam int RECIP3_SHIFT = 11;
  localparam logic signed [PROD_W:0] MID_Q16 = (PROD_W+1)'(32'sd8388608);

  localparam int SUM_W = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONTRAST,
    ST_SCALE,
    ST_PREP,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;

  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [IDX_W-1:0] idx);
    logic [GLYPH_W-1:0] g;
    unique case (idx)
      4'd0:    g = 7'd64;  // '@'
      4'd1:    g = 7'd37;  // '%'
      4'd2:    g = 7'd35;  // '#'
      4'd3:    g = 7'd42;  // '*'
      4'd4:    g = 7'd43;  // '+'
      4'd5:    g = 7'd61;  // '='
      4'd6:    g = 7'd45;  // '-'
      4'd7:    g = 7'd58;  // ':'
      4'd8:    g = 7'd46;  // '.'
      default: g = GLYPH_SPACE;
    endcase
    return g;
  endfunction

endpackage

### hdl/pbag_ifs.sv
// Channel interfaces: pixel input, glyph result and register write.
`timescale 1ns / 1ps
interface pbag_pix_if;
  logic                        valid;
  logic                        ready;
  logic [pbag_pkg::PIX_W-1:0]  red;
  logic [pbag_pkg::PIX_W-1:0]  green;
  logic [pbag_pkg::PIX_W-1:0]  blue;
  logic                        last_in_block;

  modport source (output valid, red, green, blue, last_in_block, input ready);
  modport sink   (input valid, red, green, blue, last_in_block, output ready);
endinterface

interface pbag_glyph_if;
  logic                          valid;
  logic                          ready;
  logic [pbag_pkg::GLYPH_W-1:0]  glyph_code;
  logic [pbag_pkg::IDX_W-1:0]    ramp_index;

  modport source (output valid, glyph_code, ramp_index, input ready);
  modport sink   (input valid, glyph_code, ramp_index, output ready);
endinterface

interface pbag_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pbag_pkg::CFG_IDX_W-1:0]   index;
  logic [pbag_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/pbag_div.sv
// Restoring divider, one quotient bit per cycle, 8-bit divisor.
`timescale 1ns / 1ps
module pbag_div #(
  parameter int DIVD_W = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DIVD_W-1:0]           dividend,
  input  logic [pbag_pkg::PIX_W-1:0]  divisor,
  output logic                        done,
  output logic [DIVD_W-1:0]           quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);
  localparam int W     = pbag_pkg::PIX_W;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVD_W-1:0] q_r, q_nxt;
  logic [W-1:0]      rem_r, rem_nxt;
  logic [W-1:0]      dvs_r, dvs_nxt;
  logic [W:0]        trial;
  logic              qbit;

  always_comb begin
    trial = {rem_r, q_r[DIVD_W-1]};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVD_W);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // zero divisor yields all ones, clamped downstream
      q_nxt   = {q_r[DIVD_W-2:0], qbit};
      rem_nxt = qbit ? W'(trial - {1'b0, dvs_r}) : trial[W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### hdl/pixel_block_to_ascii_glyph_top.sv
// Top level: merges block pixels and converts each finished block into a ramp glyph.
//
// Usage:
//   in_pix    pixel transfers (red, green, blue, last_in_block), valid/ready.
//   out_glyph one glyph transfer (glyph_code, ramp_index) per block, valid/ready.
//   cfg_wr    register writes: index 0 gray_min, index 1 gray_span; always ready,
//             to be written only while the block is idle.
// A pixel without last_in_block is folded into the merged pixel register and
// the next pixel is taken in the following cycle. A last pixel starts the glyph
// computation: contrast on the shared multiplier, the divide by three, a prepare
// step, the bit-serial ramp divider and the emit step, with DIVD_W = 12 for a
// ten-level ramp. in_pix is not ready during that time. The finished glyph sits
// in an output register; the next block's pixels are accepted while it waits. If
// the receiver still holds an earlier glyph when a new one is done, the sequencer
// waits in its emit step.
// Synchronous reset sets the merged pixel to mid gray 128, gray_min to 0,
// gray_span to 255 and empties the output register.
`timescale 1ns / 1ps
module pixel_block_to_ascii_glyph_top #(
  parameter int RAMP_LEVELS = pbag_pkg::RAMP_LEVELS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pbag_pix_if.sink             in_pix,
  pbag_glyph_if.source         out_glyph,
  pbag_cfg_if.sink             cfg_wr
);

  localparam int W      = pbag_pkg::PIX_W;
  localparam int DIVD_W = $clog2(255 * RAMP_LEVELS + 1);
  localparam int IDX_W  = pbag_pkg::IDX_W;
  localparam logic [DIVD_W-1:0] TOP_IDX = DIVD_W'(RAMP_LEVELS - 1);

  pbag_pkg::state_t state_r, state_nxt;

  logic [W-1:0] gray_min_r, gray_span_r;
  logic [W-1:0] merged_r [3];
  logic [1:0]   cnt_r;
  logic [pbag_pkg::SUM_W-1:0] sum_r;
  logic signed [pbag_pkg::PROD_W-1:0] prod_r;

  logic                          out_valid_r;
  logic [pbag_pkg::GLYPH_W-1:0]  glyph_r;
  logic [IDX_W-1:0]              idx_r;

  // sequencer outputs
  logic in_ready, use_recip, div_start, emit;

  logic in_xfer, out_free;
  logic [W-1:0] ch_sel;
  logic signed [pbag_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pbag_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pbag_pkg::PROD_W:0]    t_s;
  logic [W-1:0]      sat_ch;
  logic [W-1:0]      gray, x;
  logic [DIVD_W-1:0] dividend, quotient;
  logic [IDX_W-1:0]  idx;
  logic              div_done;

  assign in_xfer  = in_pix.valid && in_ready;
  assign out_free = !out_valid_r || out_glyph.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbag_pkg::ST_IDLE:     if (in_xfer && in_pix.last_in_block) begin
        state_nxt = pbag_pkg::ST_CONTRAST;
      end
      pbag_pkg::ST_CONTRAST: if (cnt_r == 2'd3) begin
        state_nxt = pbag_pkg::ST_SCALE;
      end
      pbag_pkg::ST_SCALE:    state_nxt = pbag_pkg::ST_PREP;
      pbag_pkg::ST_PREP:     state_nxt = pbag_pkg::ST_DIVIDE;
      pbag_pkg::ST_DIVIDE:   if (div_done) begin
        state_nxt = pbag_pkg::ST_EMIT;
      end
      pbag_pkg::ST_EMIT:     if (out_free) begin
        state_nxt = pbag_pkg::ST_IDLE;
      end
      default:               state_nxt = pbag_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    use_recip = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      pbag_pkg::ST_IDLE:  in_ready  = 1'b1;
      pbag_pkg::ST_SCALE: use_recip = 1'b1;
      pbag_pkg::ST_PREP:  div_start = 1'b1;
      pbag_pkg::ST_EMIT:  emit      = out_free;
      default: ;
    endcase
  end

  // channel feeding the multiplier; the fourth contrast slot is a dummy
  always_comb begin
    unique case (cnt_r)
      2'd0:    ch_sel = merged_r[0];
      2'd1:    ch_sel = merged_r[1];
      2'd2:    ch_sel = merged_r[2];
      default: ch_sel = pbag_pkg::MID_GRAY;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    if (use_recip) begin
      mul_a = pbag_pkg::RECIP3;
      mul_b = $signed({1'b0, sum_r});
    end else begin
      mul_a = pbag_pkg::GAIN_Q16;
      mul_b = $signed({3'b000, ch_sel}) - $signed(11'(pbag_pkg::MID_GRAY));
    end
  end

  // contrast saturation from the registered product
  always_comb begin
    t_s = $signed({prod_r[pbag_pkg::PROD_W-1], prod_r}) + pbag_pkg::MID_Q16;
    if (t_s[pbag_pkg::PROD_W]) begin
      sat_ch = '0;
    end else if (|t_s[pbag_pkg::PROD_W-1:24]) begin
      sat_ch = '1;
    end else begin
      sat_ch = t_s[23:16];
    end
  end

  always_comb begin
    gray     = prod_r[pbag_pkg::RECIP3_SHIFT +: W];
    x        = (gray > gray_min_r) ? W'(gray - gray_min_r) : '0;
    dividend = DIVD_W'(DIVD_W'(x) * DIVD_W'(RAMP_LEVELS));
    idx      = (quotient > TOP_IDX) ? IDX_W'(TOP_IDX) : IDX_W'(quotient);
  end

  pbag_div #(
    .DIVD_W (DIVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (gray_span_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbag_pkg::ST_IDLE;
      gray_min_r  <= pbag_pkg::GRAY_MIN_RST;
      gray_span_r <= pbag_pkg::GRAY_SPAN_RST;
      merged_r[0] <= pbag_pkg::MID_GRAY;
      merged_r[1] <= pbag_pkg::MID_GRAY;
      merged_r[2] <= pbag_pkg::MID_GRAY;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          pbag_pkg::CFG_GRAY_MIN:  gray_min_r  <= cfg_wr.data;
          pbag_pkg::CFG_GRAY_SPAN: gray_span_r <= cfg_wr.data;
          default: ;
        endcase
      end
      if (in_xfer) begin
        merged_r[0] <= W'(({1'b0, in_pix.red}   + {1'b0, merged_r[0]}) >> 1);
        merged_r[1] <= W'(({1'b0, in_pix.green} + {1'b0, merged_r[1]}) >> 1);
        merged_r[2] <= W'(({1'b0, in_pix.blue}  + {1'b0, merged_r[2]}) >> 1);
      end else if (emit) begin
        merged_r[0] <= pbag_pkg::MID_GRAY;
        merged_r[1] <= pbag_pkg::MID_GRAY;
        merged_r[2] <= pbag_pkg::MID_GRAY;
      end
      if (state_r == pbag_pkg::ST_CONTRAST) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_glyph.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (state_r == pbag_pkg::ST_IDLE) begin
      sum_r <= '0;
    end else if (state_r == pbag_pkg::ST_CONTRAST && cnt_r != 2'd0) begin
      sum_r <= sum_r + pbag_pkg::SUM_W'(sat_ch);
    end
    if (emit) begin
      glyph_r <= pbag_pkg::glyph_of(idx);
      idx_r   <= idx;
    end
  end

  assign in_pix.ready         = in_ready;
  assign cfg_wr.ready         = 1'b1;
  assign out_glyph.valid      = out_valid_r;
  assign out_glyph.glyph_code = glyph_r;
  assign out_glyph.ramp_index = idx_r;

endmodule
